@@ design/co2fd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package co2fd_pkg;

  // CRC-8 parameters of the sensor words.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Position of the last byte of a frame for each read kind.
  localparam logic [3:0] POS_LAST_MEAS   = 4'd8;
  localparam logic [3:0] POS_LAST_STATUS = 4'd2;

  // Byte positions that complete the first and second data word.
  localparam logic [3:0] POS_WORD0_LOW = 4'd1;
  localparam logic [3:0] POS_WORD1_LOW = 4'd4;

  // Read kind codes.
  localparam logic KIND_MEAS   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Conversion constants.
  localparam logic [15:0] READY_MASK  = 16'h07FF;
  localparam logic [30:0] TEMP_SCALE  = 31'd17500;
  localparam logic [30:0] RH_SCALE    = 31'd10000;
  localparam logic [30:0] ROUND_BIAS  = 31'd32767;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [31:0] FULL_SCALE  = 32'd65535;

  // Role of a byte inside its three-byte word group.
  typedef enum logic [1:0] {
    SLOT_HIGH = 2'd0,
    SLOT_LOW  = 2'd1,
    SLOT_CRC  = 2'd2
  } slot_t;

  // Frame result handed from the parser to the conversion pipeline.
  typedef struct packed {
    logic        crc_err;
    logic        kind;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] cur_word;
  } frame_res_t;

  // One CRC-8 update over a full byte, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Floor division by 65535 for values below 2^31: a shifted estimate that is
  // at most one low, followed by one remainder compare and increment.
  function automatic logic [14:0] div_by_65535(input logic [30:0] x);
    logic [31:0] sum;
    logic [15:0] q0;
    logic [31:0] rem;
    sum = {1'b0, x} + {17'b0, x[30:16]};
    q0  = sum[31:16];
    rem = {1'b0, x} + {16'b0, q0} - {q0, 16'b0};
    if (rem >= FULL_SCALE) begin
      q0 = q0 + 16'd1;
    end
    return q0[14:0];
  endfunction

endpackage

`default_nettype wire

@@ design/co2fd_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface co2fd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Decoded frame result channel.
interface co2fd_out_if;
  logic               valid;
  logic               ready;
  logic               frame_status;
  logic [15:0]        co2_ppm;
  logic signed [14:0] temp_centi;
  logic [13:0]        rh_centi;
  logic               data_ready;

  modport source (output valid, output frame_status, output co2_ppm, output temp_centi,
                  output rh_centi, output data_ready, input ready);
  modport sink (input valid, input frame_status, input co2_ppm, input temp_centi,
                input rh_centi, input data_ready, output ready);
endinterface

// Configuration write channel for the read kind register.
interface co2fd_cfg_if;
  logic valid;
  logic ready;
  logic read_kind;

  modport source (output valid, output read_kind, input ready);
  modport sink (input valid, input read_kind, output ready);
endinterface

`default_nettype wire

@@ design/co2_sensor_frame_decoder_unit.sv @@
// out_valid follows the last byte of a frame through the frame result register
// (loaded when that byte is accepted), then the scale multiply, then divide and output.
// One byte is taken per cycle while the frame result register is empty or being drained;
// a frame gives one result per 9 bytes (measurement) or per 3 bytes (status). The configuration port is always ready.
// Reset (rst_n low, synchronous): frame position 0, CRC 0xFF, error flag and
// read kind cleared, all pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module co2_sensor_frame_decoder_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  co2fd_in_if.sink     in_ch,
  co2fd_out_if.source  out_ch,
  co2fd_cfg_if.sink    cfg_ch
);

  logic                  read_kind_r;
  logic                  res_valid;
  logic                  res_ready;
  co2fd_pkg::frame_res_t res;

  // Read kind register, writable at any cycle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_kind_r <= co2fd_pkg::KIND_MEAS;
    end else if (cfg_ch.valid) begin
      read_kind_r <= cfg_ch.read_kind;
    end
  end

  // Byte parser and CRC check.
  co2fd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .read_kind   (read_kind_r),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  // Unit conversion pipeline.
  co2fd_conv u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .frame_status (out_ch.frame_status),
    .co2_ppm      (out_ch.co2_ppm),
    .temp_centi   (out_ch.temp_centi),
    .rh_centi     (out_ch.rh_centi),
    .data_ready   (out_ch.data_ready)
  );

endmodule

`default_nettype wire

@@ design/co2fd_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none

module co2fd_frame (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 read_kind,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 frame_start,
  output logic                      res_valid,
  output co2fd_pkg::frame_res_t     res,
  input  wire logic                 res_ready
);

  logic [3:0]            pos_r, pos_nxt;
  logic [7:0]            crc_r, crc_nxt;
  logic                  err_r, err_nxt;
  logic [7:0]            high_r;
  logic [7:0]            low_r;
  logic [15:0]           word0_r;
  logic [15:0]           word1_r;
  logic                  res_valid_r;
  co2fd_pkg::frame_res_t res_r;

  logic [3:0]            last_pos;
  logic [3:0]            p;
  logic [7:0]            crc_base;
  logic                  err_base;
  logic                  is_last;
  logic                  accept;
  co2fd_pkg::slot_t      slot;

  // The result register takes a new item whenever it is empty or being drained.
  assign in_ready = !res_valid_r || res_ready;
  assign accept   = in_valid && in_ready;

  // Position of this byte, with restart on frame start or an out-of-range position.
  always_comb begin
    last_pos = (read_kind == co2fd_pkg::KIND_STATUS) ? co2fd_pkg::POS_LAST_STATUS
                                                      : co2fd_pkg::POS_LAST_MEAS;
    p = frame_start ? 4'd0 : pos_r;
    if (p > last_pos) begin
      p = 4'd0;
    end
    crc_base = (p == 4'd0) ? co2fd_pkg::CRC_INIT : crc_r;
    err_base = (p == 4'd0) ? 1'b0 : err_r;
    is_last  = (p == last_pos);
  end

  // Role of the byte within its word group.
  always_comb begin
    unique case (p)
      4'd0, 4'd3, 4'd6: slot = co2fd_pkg::SLOT_HIGH;
      4'd1, 4'd4, 4'd7: slot = co2fd_pkg::SLOT_LOW;
      default:          slot = co2fd_pkg::SLOT_CRC;
    endcase
  end

  // CRC and error flag update.
  always_comb begin
    crc_nxt = crc_base;
    err_nxt = err_base;
    unique case (slot)
      co2fd_pkg::SLOT_HIGH,
      co2fd_pkg::SLOT_LOW: begin
        crc_nxt = co2fd_pkg::crc8_byte(crc_base, rx_byte);
      end
      default: begin
        err_nxt = err_base | (crc_base != rx_byte);
        crc_nxt = co2fd_pkg::CRC_INIT;
      end
    endcase
    pos_nxt = is_last ? 4'd0 : p + 4'd1;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      crc_r <= co2fd_pkg::CRC_INIT;
      err_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      err_r <= err_nxt;
    end
  end

  // Data byte and word storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (slot == co2fd_pkg::SLOT_HIGH) begin
        high_r <= rx_byte;
      end
      if (slot == co2fd_pkg::SLOT_LOW) begin
        low_r <= rx_byte;
      end
      if (p == co2fd_pkg::POS_WORD0_LOW) begin
        word0_r <= {high_r, rx_byte};
      end
      if (p == co2fd_pkg::POS_WORD1_LOW) begin
        word1_r <= {high_r, rx_byte};
      end
    end
  end

  // Frame result register, loaded on the last byte of a frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_ready) begin
      res_valid_r <= in_valid && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_last) begin
      res_r.crc_err  <= err_nxt;
      res_r.kind     <= read_kind;
      res_r.word0    <= word0_r;
      res_r.word1    <= word1_r;
      res_r.cur_word <= {high_r, low_r};
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

@@ design/co2fd_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none

module co2fd_conv (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  res_valid,
  output logic                       res_ready,
  input  wire co2fd_pkg::frame_res_t res,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       frame_status,
  output logic [15:0]                co2_ppm,
  output logic signed [14:0]         temp_centi,
  output logic [13:0]                rh_centi,
  output logic                       data_ready
);

  // Multiply stage.
  logic        mul_valid_r;
  logic        mul_err_r;
  logic        mul_meas_r;
  logic        mul_rdy_r;
  logic [15:0] mul_co2_r;
  logic [30:0] t_num_r;
  logic [30:0] h_num_r;

  // Output stage.
  logic               out_valid_r;
  logic               status_r;
  logic [15:0]        co2_r;
  logic signed [14:0] temp_r;
  logic [13:0]        rh_r;
  logic               rdy_r;

  logic        out_free;
  logic        mul_free;
  logic        meas_ok;
  logic [14:0] t_quot;
  logic [14:0] h_quot;
  logic [15:0] t_diff;

  assign out_free  = !out_valid_r || out_ready;
  assign mul_free  = !mul_valid_r || out_free;
  assign res_ready = mul_free;
  assign meas_ok   = !res.crc_err && (res.kind == co2fd_pkg::KIND_MEAS);

  // Scale products with the rounding bias folded in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_free) begin
      mul_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_free && res_valid) begin
      mul_err_r  <= res.crc_err;
      mul_meas_r <= meas_ok;
      mul_rdy_r  <= !res.crc_err && (res.kind == co2fd_pkg::KIND_STATUS) &&
                    ((res.cur_word & co2fd_pkg::READY_MASK) != 16'd0);
      mul_co2_r  <= meas_ok ? res.word0 : 16'd0;
      t_num_r    <= {15'd0, res.word1} * co2fd_pkg::TEMP_SCALE + co2fd_pkg::ROUND_BIAS;
      h_num_r    <= {15'd0, res.cur_word} * co2fd_pkg::RH_SCALE + co2fd_pkg::ROUND_BIAS;
    end
  end

  // Division by full scale and temperature offset.
  always_comb begin
    t_quot = co2fd_pkg::div_by_65535(t_num_r);
    h_quot = co2fd_pkg::div_by_65535(h_num_r);
    t_diff = {1'b0, t_quot} - co2fd_pkg::TEMP_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && mul_valid_r) begin
      status_r <= mul_err_r;
      co2_r    <= mul_co2_r;
      temp_r   <= mul_meas_r ? $signed(t_diff[14:0]) : 15'sd0;
      rh_r     <= mul_meas_r ? h_quot[13:0] : 14'd0;
      rdy_r    <= mul_rdy_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign frame_status = status_r;
  assign co2_ppm      = co2_r;
  assign temp_centi   = temp_r;
  assign rh_centi     = rh_r;
  assign data_ready   = rdy_r;

endmodule

`default_nettype wire

@@ design/co2fd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module co2fd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               frame_status,
  input wire logic [15:0]        co2_ppm,
  input wire logic signed [14:0] temp_centi,
  input wire logic [13:0]        rh_centi,
  input wire logic               data_ready
);

  // A stalled result item stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(co2_ppm) && $stable(temp_centi) &&
    $stable(rh_centi) && $stable(frame_status) && $stable(data_ready))
    else $error("result item changed while stalled");

  // A CRC error clears every data field.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_status |->
    co2_ppm == 16'd0 && temp_centi == 15'sd0 && rh_centi == 14'd0 && !data_ready)
    else $error("data fields nonzero on CRC error");

  // Data ready only comes from a status frame, which has no measurement fields.
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && data_ready |-> co2_ppm == 16'd0 && temp_centi == 15'sd0 && rh_centi == 14'd0)
    else $error("data ready together with measurement fields");

  // Converted values stay inside their physical ranges.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rh_centi <= 14'd10000 && temp_centi >= -15'sd4500 &&
    temp_centi <= 15'sd13000)
    else $error("converted value out of range");

endmodule

bind co2_sensor_frame_decoder_unit co2fd_checker u_co2fd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_status (out_ch.frame_status),
  .co2_ppm      (out_ch.co2_ppm),
  .temp_centi   (out_ch.temp_centi),
  .rh_centi     (out_ch.rh_centi),
  .data_ready   (out_ch.data_ready)
);

`default_nettype wire
